### rtl/core/hpq_pkg.sv
// Shared types and constants for the max-heap priority queue.
// No dependencies; imported by hpq_ram, hpq_seq and max_heap_priority_queue.
package hpq_pkg;

  // default heap depth in entries
  localparam int CAPACITY_DEF = 16;

  // item field widths
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  // operation codes carried on cmd
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } hpq_status_t;

  // finished result handed from the sequencer to the output register
  typedef struct packed {
    hpq_status_t        status;
    logic [VALUE_W-1:0] removed_value;
    logic [COUNT_W-1:0] entry_count;
  } hpq_res_t;

endpackage

### rtl/core/hpq_ram.sv
// Heap storage: one write port, one read port with registered read data.
// Depends on hpq_pkg for the data width and the default depth.
module hpq_ram #(
  parameter int DEPTH = hpq_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [hpq_pkg::VALUE_W-1:0]  wdata,
  input  logic [AW-1:0]                raddr,
  output logic [hpq_pkg::VALUE_W-1:0]  rdata
);
  import hpq_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/hpq_seq.sv
// Heap sequencer: insert sift-up and remove sift-down around one shared
// signed comparator and the heap RAM. Depends on hpq_pkg and hpq_ram.
module hpq_seq #(
  parameter int CAPACITY = hpq_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         cmd,
  input  logic [hpq_pkg::VALUE_W-1:0]  value,
  input  logic                         out_free,
  output logic                         idle,
  output logic                         res_valid,
  output hpq_pkg::hpq_res_t            res
);
  import hpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_UP_CHK, S_UP_CMP, S_RM_ROOT, S_RM_LAST,
    S_DN_CHK, S_DN_L, S_DN_R, S_RESULT
  } state_t;

  state_t             state;
  logic [CW-1:0]      count;
  logic [AW-1:0]      pos;
  logic [VALUE_W-1:0] cur;
  logic [VALUE_W-1:0] best;
  logic               bsel;
  hpq_status_t        st;
  logic [VALUE_W-1:0] rem;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [VALUE_W-1:0] wdata;
  logic [AW-1:0]      raddr;
  logic [VALUE_W-1:0] rdata;

  logic [VALUE_W-1:0] cmp_a;
  logic [VALUE_W-1:0] cmp_b;
  logic               gt;
  logic [AW-1:0]      parent;
  logic [IW-1:0]      left;
  logic [IW-1:0]      right;
  logic [IW-1:0]      count_ext;
  logic [CW-1:0]      last_idx;
  logic [CW+4:0]      count_wide;

  hpq_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // index arithmetic
  assign parent     = (pos - AW'(1)) >> 1;
  assign left       = {1'b0, pos, 1'b1};
  assign right      = left + IW'(1);
  assign count_ext  = IW'(count);
  assign last_idx   = count - CW'(1);
  assign count_wide = {5'b0, count};

  // shared signed comparator: cmp_a > cmp_b
  always_comb begin
    cmp_a = rdata;
    cmp_b = cur;
    case (state)
      S_UP_CMP: begin
        cmp_a = cur;
        cmp_b = rdata;
      end
      S_DN_R: begin
        cmp_b = best;
      end
      default: ;
    endcase
  end
  assign gt = $signed(cmp_a) > $signed(cmp_b);

  // RAM port control; the moving value sits in cur, the hole at pos
  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = cur;
    raddr = '0;
    case (state)
      S_UP_CHK: begin
        if (pos == '0) begin
          we = 1'b1;
        end else begin
          raddr = parent;
        end
      end
      S_UP_CMP: begin
        we    = 1'b1;
        wdata = gt ? rdata : cur;
      end
      S_RM_ROOT: begin
        raddr = last_idx[AW-1:0];
      end
      S_DN_CHK: begin
        if (left >= count_ext) begin
          we = 1'b1;
        end else begin
          raddr = left[AW-1:0];
        end
      end
      S_DN_L: begin
        if (right < count_ext) begin
          raddr = right[AW-1:0];
        end else begin
          we    = 1'b1;
          wdata = gt ? rdata : cur;
        end
      end
      S_DN_R: begin
        we    = 1'b1;
        wdata = gt ? rdata : best;
      end
      default: ;
    endcase
  end

  // result towards the output register
  assign idle                = (state == S_IDLE);
  assign res_valid           = (state == S_RESULT) && out_free;
  assign res.status          = st;
  assign res.removed_value   = rem;
  assign res.entry_count     = count_wide[COUNT_W-1:0];

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            rem <= '0;
            if (cmd == CMD_INSERT) begin
              if (count == CW'(CAPACITY)) begin
                st    <= ST_OVERFLOW;
                state <= S_RESULT;
              end else begin
                st    <= ST_DONE;
                pos   <= count[AW-1:0];
                cur   <= value;
                count <= count + CW'(1);
                state <= S_UP_CHK;
              end
            end else begin
              if (count == '0) begin
                st    <= ST_EMPTY;
                state <= S_RESULT;
              end else begin
                st    <= ST_DONE;
                state <= S_RM_ROOT;
              end
            end
          end
        end
        S_UP_CHK: begin
          state <= (pos == '0) ? S_RESULT : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (gt) begin
            pos   <= parent;
            state <= S_UP_CHK;
          end else begin
            state <= S_RESULT;
          end
        end
        S_RM_ROOT: begin
          rem   <= rdata;
          count <= last_idx;
          state <= (count == CW'(1)) ? S_RESULT : S_RM_LAST;
        end
        S_RM_LAST: begin
          cur   <= rdata;
          pos   <= '0;
          state <= S_DN_CHK;
        end
        S_DN_CHK: begin
          state <= (left >= count_ext) ? S_RESULT : S_DN_L;
        end
        S_DN_L: begin
          best <= gt ? rdata : cur;
          bsel <= gt;
          if (right < count_ext) begin
            state <= S_DN_R;
          end else if (gt) begin
            pos   <= left[AW-1:0];
            state <= S_DN_CHK;
          end else begin
            state <= S_RESULT;
          end
        end
        S_DN_R: begin
          if (gt) begin
            pos   <= right[AW-1:0];
            state <= S_DN_CHK;
          end else if (bsel) begin
            pos   <= left[AW-1:0];
            state <= S_DN_CHK;
          end else begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_write_in_heap: assert property (@(posedge clk) disable iff (rst)
    we |-> (CW'(waddr) < count))
    else $error("heap write outside held entries");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> idle)
    else $error("item started while busy");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (res_valid && st == ST_OVERFLOW) |-> (count == CW'(CAPACITY)))
    else $error("overflow reported on a heap with room");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && st == ST_EMPTY) |-> (count == '0 && rem == '0))
    else $error("empty reported on a non-empty heap");

endmodule

### rtl/core/max_heap_priority_queue.sv
// Max-heap priority queue top level: handshakes, output register, sequencer.
// Insert: per level S_UP_CHK reads the parent, S_UP_CMP compares and writes; the value
// is written at the root if it gets there; then the result. Remove: S_RM_ROOT, S_RM_LAST
// read root and last entry, then per node S_DN_CHK, S_DN_L and S_DN_R read the children
// and write, then the result. One item in flight. Reset clears state, count, out_valid.
// The result waits in the output register while the next item runs.
module max_heap_priority_queue #(
  parameter int CAPACITY = hpq_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cmd,
  input  logic signed [hpq_pkg::VALUE_W-1:0] value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic signed [hpq_pkg::VALUE_W-1:0] removed_value,
  output logic [hpq_pkg::COUNT_W-1:0]   entry_count
);
  import hpq_pkg::*;

  logic     start;
  logic     idle;
  logic     out_free;
  logic     res_valid;
  hpq_res_t res;

  assign in_ready = idle;
  assign start    = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  hpq_seq #(.CAPACITY(CAPACITY)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .value     (value),
    .out_free  (out_free),
    .idle      (idle),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      status        <= res.status;
      removed_value <= res.removed_value;
      entry_count   <= res.entry_count;
    end
  end

endmodule
